// ----- sv/rtp_rollover_counter_tracker_defines.svh -----
// Assertion macros used by the top level of the rollover counter tracker RTL.
`ifndef RTP_ROLLOVER_COUNTER_TRACKER_DEFINES_SVH
`define RTP_ROLLOVER_COUNTER_TRACKER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RRCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrct: same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define RRCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrct: next-cycle check failed");

`endif

// ----- sv/rrct_pkg.sv -----
// Shared types and constants of the rollover counter tracker.
package rrct_pkg;

  localparam int SSRC_W = 32;
  localparam int SEQ_W  = 16;
  localparam int ROC_W  = 32;

  // A sequence jump of more than a quarter of the number space marks a
  // rollover (forward) or a late packet from the previous cycle (backward).
  localparam logic signed [SEQ_W:0] QUARTER_TURN     = 17'sd16384;
  localparam logic signed [SEQ_W:0] NEG_QUARTER_TURN = -17'sd16384;

  // Result of the table lookup for the current request.
  typedef struct packed {
    logic             hit;
    logic             free;
    logic [SEQ_W-1:0] last_seq;
    logic [ROC_W-1:0] roc;
  } lookup_t;

  // Write-back into the table: update the matching entry or insert a new one.
  typedef struct packed {
    logic             upd;
    logic             ins;
    logic [SEQ_W-1:0] seq;
    logic [ROC_W-1:0] roc;
  } wb_t;

endpackage

// ----- sv/rrct_table.sv -----
// Stream table: entry storage, parallel id match, free slot search, write-back.
module rrct_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rrct_pkg::SSRC_W-1:0] ssrc,
  input  logic                       fire,
  input  rrct_pkg::wb_t              wb,
  output rrct_pkg::lookup_t          lk
);

  logic [TABLE_ENTRIES-1:0] valid;
  logic [rrct_pkg::SSRC_W-1:0] entry_ssrc [TABLE_ENTRIES];
  logic [rrct_pkg::SEQ_W-1:0]  entry_seq  [TABLE_ENTRIES];
  logic [rrct_pkg::ROC_W-1:0]  entry_roc  [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] hit_oh;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic [rrct_pkg::SEQ_W-1:0] rd_seq;
  logic [rrct_pkg::ROC_W-1:0] rd_roc;

  // Ids are unique among valid entries, so at most one entry matches.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_oh[i] = valid[i] && (entry_ssrc[i] == ssrc);
    end
  end

  // Lowest clear valid bit, isolated by the add-and-mask trick.
  assign free_oh = ~valid & (valid + TABLE_ENTRIES'(1));

  always_comb begin
    rd_seq = '0;
    rd_roc = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        rd_seq = rd_seq | entry_seq[i];
        rd_roc = rd_roc | entry_roc[i];
      end
    end
  end

  assign lk.hit      = |hit_oh;
  assign lk.free     = |free_oh;
  assign lk.last_seq = rd_seq;
  assign lk.roc      = rd_roc;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (fire && wb.ins) begin
      valid <= valid | free_oh;
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (fire && ((wb.upd && hit_oh[g]) || (wb.ins && free_oh[g]))) begin
        entry_seq[g] <= wb.seq;
        entry_roc[g] <= wb.roc;
        if (wb.ins) begin
          entry_ssrc[g] <= ssrc;
        end
      end
    end
  end

endmodule

// ----- sv/rrct_update.sv -----
// Rollover decision: classifies the sequence jump and forms result and write-back.
module rrct_update (
  input  rrct_pkg::lookup_t          lk,
  input  logic [rrct_pkg::SEQ_W-1:0] seq,
  output rrct_pkg::wb_t              wb,
  output logic [rrct_pkg::ROC_W-1:0] roc,
  output logic                       is_new,
  output logic                       table_full
);

  logic signed [rrct_pkg::SEQ_W:0] diff;
  logic [rrct_pkg::ROC_W-1:0] roc_inc;
  logic [rrct_pkg::ROC_W-1:0] roc_dec;

  assign diff    = $signed({1'b0, lk.last_seq}) - $signed({1'b0, seq});
  assign roc_inc = lk.roc + rrct_pkg::ROC_W'(1);
  assign roc_dec = lk.roc - rrct_pkg::ROC_W'(1);

  always_comb begin
    wb         = '0;
    wb.seq     = seq;
    roc        = '0;
    is_new     = 1'b0;
    table_full = 1'b0;
    if (lk.hit) begin
      if (diff > rrct_pkg::QUARTER_TURN) begin
        wb.upd = 1'b1;
        wb.roc = roc_inc;
        roc    = roc_inc;
      end else if (diff < rrct_pkg::NEG_QUARTER_TURN) begin
        roc = roc_dec;
      end else begin
        wb.upd = seq > lk.last_seq;
        wb.roc = lk.roc;
        roc    = lk.roc;
      end
    end else if (lk.free) begin
      wb.ins = 1'b1;
      is_new = 1'b1;
    end else begin
      table_full = 1'b1;
    end
  end

endmodule

// ----- sv/rtp_rollover_counter_tracker.sv -----
// Top level of the RTP rollover counter tracker.
// The tracker estimates the rollover counter of each RTP stream from the
// stream id and sequence number of every request. It keeps a table of
// TABLE_ENTRIES streams in flip-flops, all compared in parallel. A new
// request is taken every clock cycle unless the result side stalls; it
// goes through the input and result registers. The table update of one
// request is complete before the next request is looked up, so back-to-back
// packets of the same stream are handled exactly. A stream seen for the
// first time takes the lowest free entry and gets roc 0 with is_new set; an
// unknown stream that finds the table full gets roc 0 with table_full set
// and is not stored. Entries are never evicted; reset empties the table at
// once, with no clearing pass. A jump back of more than a quarter of the
// sequence space reports the previous counter and leaves the entry alone.
`include "rtp_rollover_counter_tracker_defines.svh"

module rtp_rollover_counter_tracker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pkt_valid,
  output logic                        pkt_stall,
  input  logic [rrct_pkg::SSRC_W-1:0] ssrc,
  input  logic [rrct_pkg::SEQ_W-1:0]  seq_num,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [rrct_pkg::ROC_W-1:0]  roc,
  output logic                        is_new,
  output logic                        table_full
);

  // Input register stage.
  logic                        s1_vld;
  logic                        s1_vld_next;
  logic [rrct_pkg::SSRC_W-1:0] s1_ssrc;
  logic [rrct_pkg::SEQ_W-1:0]  s1_seq;

  // The request in the input register moves on whenever the result register
  // is empty or its content is being taken this cycle.
  logic s1_go;
  logic fire;
  logic take;

  rrct_pkg::lookup_t          lk;
  rrct_pkg::wb_t              wb;
  logic [rrct_pkg::ROC_W-1:0] roc_c;
  logic                       is_new_c;
  logic                       full_c;

  assign s1_go     = !res_valid || !res_stall;
  assign fire      = s1_vld && s1_go;
  assign pkt_stall = s1_vld && !s1_go;
  assign take      = pkt_valid && !pkt_stall;

  always_comb begin
    s1_vld_next = s1_vld;
    if (take) begin
      s1_vld_next = 1'b1;
    end else if (s1_go) begin
      s1_vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= s1_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ssrc <= ssrc;
      s1_seq  <= seq_num;
    end
  end

  rrct_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .ssrc (s1_ssrc),
    .fire (fire),
    .wb   (wb),
    .lk   (lk)
  );

  rrct_update u_update (
    .lk         (lk),
    .seq        (s1_seq),
    .wb         (wb),
    .roc        (roc_c),
    .is_new     (is_new_c),
    .table_full (full_c)
  );

  // Result register: holds its content while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      roc        <= roc_c;
      is_new     <= is_new_c;
      table_full <= full_c;
    end
  end

  // A result never claims both a new entry and a full table.
  `RRCT_ASSERT_NOW(a_flags_excl, res_valid, !(is_new && table_full))
  // New streams and rejected streams both report a counter of zero.
  `RRCT_ASSERT_NOW(a_zero_roc, res_valid && (is_new || table_full), roc == '0)
  // A request held in the input register is not dropped while blocked.
  `RRCT_ASSERT_NEXT(a_s1_hold, s1_vld && !s1_go, s1_vld && $stable(s1_seq))

endmodule

// ----- test/rtp_rollover_counter_tracker_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the RTP rollover counter tracker.
module rtp_rollover_counter_tracker_tb;

  // The table size of the instance; the stimulus relies on it to fill the
  // table completely during the directed part.
  localparam int STREAMS = 16;

  // Random requests after the directed part, for roughly 1150 requests in total.
  localparam int RANDOM_REQUESTS = 1125;

  // The run is cut off after this many nanoseconds, far beyond what a correct
  // run takes with the random idling and stalls.
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // One expected answer of the tracker, in the order the requests were taken.
  typedef struct packed {
    logic [rrct_pkg::ROC_W-1:0] roc;
    logic                       is_new;
    logic                       table_full;
  } roc_answer_t;

  // The scoreboard keeps its own copy of the stream table. Every accepted
  // request is run through that copy to work out its answer, and every answer
  // that leaves the block is compared with the oldest answer still waiting.
  class roc_scoreboard;
    logic                        used[STREAMS];
    logic [rrct_pkg::SSRC_W-1:0] id_tab[STREAMS];
    logic [rrct_pkg::SEQ_W-1:0]  seq_tab[STREAMS];
    logic [rrct_pkg::ROC_W-1:0]  roc_tab[STREAMS];
    roc_answer_t                 pending[$];
    int                          mismatches;
    int                          checked;
    int                          rollovers;
    int                          late_packets;
    int                          new_streams;
    int                          rejects;

    function new();
      for (int i = 0; i < STREAMS; i++) begin
        used[i]    = 1'b0;
        id_tab[i]  = '0;
        seq_tab[i] = '0;
        roc_tab[i] = '0;
      end
      mismatches   = 0;
      checked      = 0;
      rollovers    = 0;
      late_packets = 0;
      new_streams  = 0;
      rejects      = 0;
    endfunction

    // Runs one accepted request through the table copy and queues its answer.
    function void note_request(logic [rrct_pkg::SSRC_W-1:0] id,
                               logic [rrct_pkg::SEQ_W-1:0] sq);
      int          hit;
      int          free_slot;
      int          diff;
      roc_answer_t ans;
      hit       = -1;
      free_slot = -1;
      ans       = '0;
      for (int i = 0; i < STREAMS; i++) begin
        if (used[i]) begin
          if (hit < 0 && id_tab[i] == id) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        // The distance is taken on the plain sequence values, not modulo 2^16.
        diff = int'(seq_tab[hit]) - int'(sq);
        if (diff > 16384) begin
          // The sequence wrapped forward: a new rollover cycle begins.
          seq_tab[hit] = sq;
          roc_tab[hit] = roc_tab[hit] + 1'b1;
          ans.roc      = roc_tab[hit];
          rollovers++;
        end else if (diff < -16384) begin
          // A late packet from before the last wrap; the entry stays as it is.
          ans.roc = roc_tab[hit] - 1'b1;
          late_packets++;
        end else begin
          if (sq > seq_tab[hit]) seq_tab[hit] = sq;
          ans.roc = roc_tab[hit];
        end
      end else if (free_slot >= 0) begin
        used[free_slot]    = 1'b1;
        id_tab[free_slot]  = id;
        seq_tab[free_slot] = sq;
        roc_tab[free_slot] = '0;
        ans.is_new         = 1'b1;
        new_streams++;
      end else begin
        ans.table_full = 1'b1;
        rejects++;
      end
      pending.push_back(ans);
    endfunction

    // Compares one result of the block with the oldest waiting answer.
    function void check_result(logic [rrct_pkg::ROC_W-1:0] r, logic n, logic f);
      roc_answer_t want;
      checked++;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request waiting: roc=%h is_new=%b table_full=%b",
                   $realtime, r, n, f);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (r !== want.roc || n !== want.is_new || f !== want.table_full) begin
          if (mismatches < 10)
            $display({"%0t: result %0d: expected roc=%h is_new=%b table_full=%b,",
                      " got roc=%h is_new=%b table_full=%b"},
                     $realtime, checked, want.roc, want.is_new, want.table_full,
                     r, n, f);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        pkt_valid  = 1'b0;
  logic                        pkt_stall;
  logic [rrct_pkg::SSRC_W-1:0] ssrc       = '0;
  logic [rrct_pkg::SEQ_W-1:0]  seq_num    = '0;
  logic                        res_valid;
  logic                        res_stall  = 1'b0;
  logic [rrct_pkg::ROC_W-1:0]  roc;
  logic                        is_new;
  logic                        table_full;

  // While quiet is set, neither side idles, so the block runs at full rate.
  logic                        quiet      = 1'b0;

  roc_scoreboard               sb = new();

  rtp_rollover_counter_tracker #(
    .TABLE_ENTRIES(STREAMS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .ssrc      (ssrc),
    .seq_num   (seq_num),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .roc       (roc),
    .is_new    (is_new),
    .table_full(table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls in about six percent of the cycles, except during
  // the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= !quiet && ($urandom_range(99) < 6);
    end
  end

  // Results are sampled at the clock edge, where the values seen are the ones
  // that were stable just before it.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(roc, is_new, table_full);
  end

  // Presents one request and holds it until the block takes it. An idle gap
  // may come first. The request is handed to the scoreboard at the edge where
  // it is taken, so the table copy is up to date before the next request is
  // chosen.
  task automatic send_request(input logic [rrct_pkg::SSRC_W-1:0] id,
                              input logic [rrct_pkg::SEQ_W-1:0] sq);
    while (!quiet && $urandom_range(99) < 6) begin
      pkt_valid <= 1'b0;
      @(posedge clk);
    end
    pkt_valid <= 1'b1;
    ssrc      <= id;
    seq_num   <= sq;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    sb.note_request(id, sq);
  endtask

  initial begin : stimulus
    logic [rrct_pkg::SSRC_W-1:0] known_ids[STREAMS];
    logic [rrct_pkg::SSRC_W-1:0] id;
    logic [rrct_pkg::SEQ_W-1:0]  sq;
    logic [rrct_pkg::SEQ_W-1:0]  cur;
    int                          k;
    int                          r;

    // The streams that fill the table, in the order they are first seen, so
    // that stream k always sits in table entry k.
    known_ids[0] = 32'h0000_0000;
    known_ids[1] = 32'hFFFF_FFFF;
    known_ids[2] = 32'h1234_5678;
    for (int i = 3; i < STREAMS; i++) known_ids[i] = 32'h1 << (i - 3);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first stream walks through every branch of the
    // sequence comparison, including both edges of the quarter-turn window.
    send_request(known_ids[0], 16'd0);      // new stream
    send_request(known_ids[0], 16'd100);    // small step forward
    send_request(known_ids[0], 16'd50);     // small step back, nothing stored
    send_request(known_ids[0], 16'd16484);  // exactly a quarter turn ahead
    send_request(known_ids[0], 16'd100);    // exactly a quarter turn behind
    send_request(known_ids[0], 16'd99);     // one past it: a rollover
    // Extreme stream id and sequence values, and a full wrap of the sequence.
    send_request(known_ids[1], 16'hFFFF);
    send_request(known_ids[1], 16'h0000);
    // A late packet right after the stream starts makes the counter wrap
    // below zero.
    send_request(known_ids[2], 16'd10);
    send_request(known_ids[2], 16'd30000);
    send_request(known_ids[0], 16'hFFFF);
    // Fill the rest of the table, then an unknown stream finds it full, and a
    // known stream is still served after that.
    for (int i = 3; i < STREAMS; i++) send_request(known_ids[i], 16'(i * 4000));
    send_request(32'hDEAD_BEEF, 16'd7);
    send_request(known_ids[5], 16'd20100);

    // Random part. Most requests continue one of the known streams from its
    // stored sequence number, so the streams keep wrapping and the counters
    // keep growing. The rest are small reorders, late packets from before a
    // wrap, arbitrary jumps and unknown streams that the full table rejects.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet <= (n >= 400 && n < 700);
      k   = int'($urandom_range(STREAMS - 1));
      id  = known_ids[k];
      cur = sb.seq_tab[k];
      r   = int'($urandom_range(99));
      if (r < 5) begin
        id = $urandom();
        sq = 16'($urandom());
      end else if (r < 78) begin
        sq = cur + 16'($urandom_range(4000, 1));
      end else if (r < 88) begin
        sq = cur - 16'($urandom_range(2000, 1));
      end else if (r < 95) begin
        sq = cur + 16'($urandom_range(40000, 16385));
      end else begin
        sq = 16'($urandom());
      end
      send_request(id, sq);
    end
    pkt_valid <= 1'b0;
    quiet     <= 1'b0;

    // Wait for every answer, then a few more cycles so that a stray extra
    // result would still be caught.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d new streams, %0d rejected by the full table,",
             sb.checked, sb.new_streams, sb.rejects);
    $display("%0d rollovers and %0d late packets; %0d mismatches.",
             sb.rollovers, sb.late_packets, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("rtp_rollover_counter_tracker test passed");
    end else begin
      $display("rtp_rollover_counter_tracker test failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run stopped by the timeout with %0d answers still waiting.",
             sb.pending.size());
    $display("rtp_rollover_counter_tracker test failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/rrct_pkg.sv
sv/rrct_table.sv
sv/rrct_update.sv
sv/rtp_rollover_counter_tracker.sv
test/rtp_rollover_counter_tracker_tb.sv
